/* design/ccm_pkg.sv */
// ----------------------------------------------------------------------------
// Coldest-core mapper package
// Opcodes, result status codes and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ccm_pkg;

  // Temperature store depth and the matching core index width.
  localparam int STORE_DEPTH = 16;
  localparam int IDX_W       = 4;
  localparam int TEMP_W      = 16;

  // Request opcodes.
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_MAP     = 2'd1;
  localparam logic [1:0] OP_MIGRATE = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_CHOSEN   = 3'd0;
  localparam logic [2:0] ST_MIGRATE  = 3'd1;
  localparam logic [2:0] ST_FEW      = 3'd2;
  localparam logic [2:0] ST_NOTARGET = 3'd3;
  localparam logic [2:0] ST_NOTHING  = 3'd4;

  // Reset value of the critical temperature (80 degrees in 1/16 steps).
  localparam logic signed [15:0] CRIT_RESET = 16'sd1280;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write;         // store one core temperature
    logic load;          // capture a map or migrate request
    logic hot_step;      // classify one active core as hot or not
    logic scan_start;    // restart the coldest-core scan
    logic src_pick;      // take the lowest remaining hot core as source
    logic scan_step;     // examine one core in the coldest-core scan
    logic emit_pick;     // emit the result of a finished scan
    logic emit_nothing;  // emit the zero-count result
    logic emit_few;      // emit the not-enough-cores result
  } ccm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_zero;     // map request asks for no cores
    logic too_few;       // map request asks for more cores than are free
    logic idx_last;      // sweep index is on the last core
    logic hot_empty;     // no hot core is left to migrate
    logic is_map;        // current request is a map request
    logic pick_last;     // the pending pick is the last result
  } ccm_stat_t;

endpackage

`default_nettype wire

/* design/ccm_ctrl.sv */
// ----------------------------------------------------------------------------
// Coldest-core mapper controller
// Sequences the request phases and drives datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ccm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [1:0]       in_opcode,
  input  wire ccm_pkg::ccm_stat_t stat,
  output ccm_pkg::ccm_cmd_t     cmd,
  output logic                  busy
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_HOT   = 6'b000100,
    S_SRC   = 6'b001000,
    S_SCAN  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_opcode)
            ccm_pkg::OP_WRITE: begin
              cmd.write = 1'b1;
            end
            ccm_pkg::OP_MAP: begin
              cmd.load  = 1'b1;
              state_nxt = S_CHECK;
            end
            ccm_pkg::OP_MIGRATE: begin
              cmd.load  = 1'b1;
              state_nxt = S_HOT;
            end
            default: begin
            end
          endcase
        end
      end
      S_CHECK: begin
        if (stat.need_zero) begin
          cmd.emit_nothing = 1'b1;
          state_nxt        = S_IDLE;
        end else if (stat.too_few) begin
          cmd.emit_few = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_HOT: begin
        cmd.hot_step = 1'b1;
        if (stat.idx_last) begin
          state_nxt = S_SRC;
        end
      end
      S_SRC: begin
        if (stat.hot_empty) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.src_pick = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.idx_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit_pick = 1'b1;
        if (stat.is_map) begin
          state_nxt = stat.pick_last ? S_IDLE : S_SCAN;
        end else begin
          state_nxt = S_SRC;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

/* design/ccm_datapath.sv */
// ----------------------------------------------------------------------------
// Coldest-core mapper datapath
// Temperature store, request masks, one-core-per-cycle coldest scan and the
// registered result port.
// ----------------------------------------------------------------------------
`default_nettype none

module ccm_datapath #(
  parameter int CORE_TOTAL = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire ccm_pkg::ccm_cmd_t        cmd,
  output ccm_pkg::ccm_stat_t            stat,
  input  wire logic                     cfg_wr_en,
  input  wire logic signed [15:0]       cfg_wr_data,
  input  wire logic [1:0]               in_opcode,
  input  wire logic [3:0]               in_core_index,
  input  wire logic signed [15:0]       in_temperature_value,
  input  wire logic [6:0]               in_core_count,
  input  wire logic [15:0]              in_free_mask,
  input  wire logic [15:0]              in_active_mask,
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [3:0]                    out_from_core,
  output logic [3:0]                    out_to_core,
  output logic                          out_last
);

  localparam logic [16:0] VALID_WIDE = (17'd1 << CORE_TOTAL) - 17'd1;
  localparam logic [15:0] VALID_MASK = VALID_WIDE[15:0];
  localparam logic [3:0]  IDX_LAST   = 4'(CORE_TOTAL - 1);

  logic signed [15:0] temp_r [ccm_pkg::STORE_DEPTH];
  logic signed [15:0] crit_r;
  logic [15:0]        free_r;
  logic [15:0]        active_r;
  logic [15:0]        hot_r;
  logic [6:0]         need_r;
  logic               is_map_r;
  logic [3:0]         idx_r;
  logic [3:0]         src_r;
  logic [3:0]         best_idx_r;
  logic signed [15:0] best_temp_r;
  logic               found_r;
  logic               out_valid_r;
  logic [2:0]         out_status_r;
  logic [3:0]         out_from_r;
  logic [3:0]         out_to_r;
  logic               out_last_r;

  logic signed [15:0] temp_rd;
  logic [4:0]         have;
  logic [3:0]         hot_low;
  logic [15:0]        hot_after;
  logic [3:0]         idx_nxt;
  logic               better;
  logic               pick_last;

  assign temp_rd = temp_r[idx_r];
  assign idx_nxt = (idx_r == IDX_LAST) ? 4'd0 : idx_r + 4'd1;
  assign better  = free_r[idx_r] && (!found_r || (temp_rd < best_temp_r));

  always_comb begin
    have = '0;
    for (int i = 0; i < ccm_pkg::STORE_DEPTH; i++) begin
      have = have + {4'd0, free_r[i]};
    end
  end

  // Lowest-index hot core still waiting for a target.
  always_comb begin
    hot_low = '0;
    for (int i = ccm_pkg::STORE_DEPTH - 1; i >= 0; i--) begin
      if (hot_r[i]) begin
        hot_low = 4'(i);
      end
    end
  end

  assign hot_after = hot_r & ~(16'd1 << src_r);
  assign pick_last = is_map_r ? (need_r == 7'd1) : (hot_after == 16'd0);

  always_comb begin
    stat.need_zero = (need_r == 7'd0);
    stat.too_few   = (need_r > {2'b00, have});
    stat.idx_last  = (idx_r == IDX_LAST);
    stat.hot_empty = (hot_r == 16'd0);
    stat.is_map    = is_map_r;
    stat.pick_last = pick_last;
  end

  // Control state and the temperature store, which resets to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ccm_pkg::STORE_DEPTH; i++) begin
        temp_r[i] <= '0;
      end
      crit_r      <= ccm_pkg::CRIT_RESET;
      free_r      <= '0;
      hot_r       <= '0;
      need_r      <= '0;
      is_map_r    <= 1'b0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_pick | cmd.emit_nothing | cmd.emit_few;
      if (cfg_wr_en) begin
        crit_r <= cfg_wr_data;
      end
      if (cmd.write) begin
        temp_r[in_core_index] <= in_temperature_value;
      end
      if (cmd.load) begin
        is_map_r <= (in_opcode == ccm_pkg::OP_MAP);
        free_r   <= in_free_mask & VALID_MASK;
        need_r   <= in_core_count;
        hot_r    <= '0;
        idx_r    <= '0;
      end
      if (cmd.hot_step) begin
        hot_r[idx_r] <= active_r[idx_r] && (temp_rd > crit_r);
        idx_r        <= idx_nxt;
      end
      if (cmd.scan_start || cmd.src_pick) begin
        idx_r   <= '0;
        found_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        idx_r <= idx_nxt;
        if (better) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.emit_pick) begin
        idx_r   <= '0;
        found_r <= 1'b0;
        if (found_r) begin
          free_r[best_idx_r] <= 1'b0;
        end
        if (is_map_r) begin
          need_r <= need_r - 7'd1;
        end else begin
          hot_r <= hot_after;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      active_r <= in_active_mask & VALID_MASK;
    end
    if (cmd.src_pick) begin
      src_r <= hot_low;
    end
    if (cmd.scan_step && better) begin
      best_idx_r  <= idx_r;
      best_temp_r <= temp_rd;
    end
    if (cmd.emit_nothing) begin
      out_status_r <= ccm_pkg::ST_NOTHING;
      out_from_r   <= '0;
      out_to_r     <= '0;
      out_last_r   <= 1'b1;
    end
    if (cmd.emit_few) begin
      out_status_r <= ccm_pkg::ST_FEW;
      out_from_r   <= '0;
      out_to_r     <= '0;
      out_last_r   <= 1'b1;
    end
    if (cmd.emit_pick) begin
      out_last_r <= pick_last;
      if (is_map_r) begin
        out_status_r <= ccm_pkg::ST_CHOSEN;
        out_from_r   <= '0;
        out_to_r     <= best_idx_r;
      end else if (found_r) begin
        out_status_r <= ccm_pkg::ST_MIGRATE;
        out_from_r   <= src_r;
        out_to_r     <= best_idx_r;
      end else begin
        out_status_r <= ccm_pkg::ST_NOTARGET;
        out_from_r   <= src_r;
        out_to_r     <= '0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_from_core = out_from_r;
  assign out_to_core   = out_to_r;
  assign out_last      = out_last_r;

  // A map pick always finds a core, since the count was checked first.
  a_map_finds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_pick && is_map_r |-> found_r)
    else $error("map pick emitted without a free core");

  // The chosen core is still free when it is handed out.
  a_pick_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_pick && found_r |-> free_r[best_idx_r])
    else $error("chosen core was not free");

  // Once handed out, a core leaves the working free set.
  a_pick_taken: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_pick && found_r |=> !free_r[$past(best_idx_r)])
    else $error("chosen core still free after pick");

  // A result strobe is always caused by an emit command in the cycle before.
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd.emit_pick || cmd.emit_nothing || cmd.emit_few))
    else $error("result strobe without an emit command");

endmodule

`default_nettype wire

/* design/coldest_core_mapper.sv */
// ----------------------------------------------------------------------------
// Coldest-core mapper
// Keeps one temperature per core and answers map and migrate requests with
// the coldest free cores.
// ----------------------------------------------------------------------------
// Usage: a request is taken at a rising edge where start is high and busy is
// low. Opcode write stores in_temperature_value for in_core_index in that
// same edge and leaves busy low, so writes can be issued every cycle. A map
// request (opcode 1) or migrate request (opcode 2) raises busy until it is done,
// after its last result if it issues any; unused opcode 3 is ignored.
// Each result appears on the out_ ports for exactly one cycle with out_valid
// high, and out_last marks the final result of a request. The receiver has
// no way to stall the block and must take every strobe.
// Steps, with N = min(CORE_ROWS * CORE_COLUMNS, 16) cores: every pick is a
// scan of the temperature store, one core per cycle through a single read
// port, followed by an emit step. A map request first checks the free
// count, then runs one pick per requested core. A migrate request first
// sweeps the N cores to find the hot active ones, then for each hot core
// selects it as source and runs its pick, and ends with a source-select
// step that finds no hot core left; with none at all it issues no result.
// cfg_wr_en writes the critical temperature; write it only while idle.
// Reset (synchronous, active low) clears all core temperatures to zero and
// sets the critical temperature to 1280 (80 degrees).
// ----------------------------------------------------------------------------
`default_nettype none

module coldest_core_mapper #(
  parameter int CORE_ROWS    = 4,
  parameter int CORE_COLUMNS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic signed [15:0] cfg_wr_data,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [3:0]         in_core_index,
  input  wire logic signed [15:0] in_temperature_value,
  input  wire logic [6:0]         in_core_count,
  input  wire logic [15:0]        in_free_mask,
  input  wire logic [15:0]        in_active_mask,
  output logic                    out_valid,
  output logic [2:0]              out_status,
  output logic [3:0]              out_from_core,
  output logic [3:0]              out_to_core,
  output logic                    out_last
);

  // Cores beyond the store depth are never scanned.
  localparam int CORE_GRID  = CORE_ROWS * CORE_COLUMNS;
  localparam int CORE_TOTAL = (CORE_GRID > ccm_pkg::STORE_DEPTH) ?
                              ccm_pkg::STORE_DEPTH : CORE_GRID;

  ccm_pkg::ccm_cmd_t  cmd;
  ccm_pkg::ccm_stat_t stat;

  // The controller sequences check, hot sweep, source select, scan and emit.
  ccm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  // The datapath holds the store, the working masks and the result register.
  ccm_datapath #(
    .CORE_TOTAL (CORE_TOTAL)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_opcode            (in_opcode),
    .in_core_index        (in_core_index),
    .in_temperature_value (in_temperature_value),
    .in_core_count        (in_core_count),
    .in_free_mask         (in_free_mask),
    .in_active_mask       (in_active_mask),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_from_core        (out_from_core),
    .out_to_core          (out_to_core),
    .out_last             (out_last)
  );

endmodule

`default_nettype wire
